// ===== design/u8u16_pkg.sv =====
// shared types and constants of the utf-8 to utf-16 (bmp) decoder
// no dependencies; imported by every module of the block
`default_nettype none

package u8u16_pkg;

   // unit and counter widths
   localparam int UNIT_W  = 16;
   localparam int COUNT_W = 15;

   // four-entry queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [UNIT_W-1:0]  BOM_UNIT  = 16'hFEFF;
   localparam logic [UNIT_W-1:0]  TERM_UNIT = 16'h0000;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7FFF;

   // lead byte classes, by top bits
   localparam logic [3:0] LEAD3_TAG = 4'hE;
   localparam logic [2:0] LEAD2_TAG = 3'b110;

   // continuation bytes still expected
   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_ONE  = 2'd1;
   localparam logic [1:0] PEND_TWO  = 2'd2;

   // one queue entry: the results caused by one byte
   typedef struct packed {
      logic               mark;     // 0xFEFF marker
      logic               unit_v;   // decoded or truncated unit
      logic [UNIT_W-1:0]  unit;
      logic               term;     // terminator
      logic               stop;     // invalid lead seen in this string
      logic [COUNT_W-1:0] count;    // units given, marker included
   } rec_type;

   // queue status seen by front and back
   typedef struct packed {
      logic full;
      logic not_empty;
   } q_status_type;

endpackage

`default_nettype wire

// ===== design/u8u16_front.sv =====
// front end: accepts input words, decodes utf-8 and queues result records
// depends on u8u16_pkg
`default_nettype none

module u8u16_front
   import u8u16_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic [7:0]   req_in_byte,
   input  wire logic         req_end_of_string,
   output logic              req_stall,
   input  wire q_status_type q_status,
   output logic              push,
   output rec_type           rec
);

   logic               marker_sent_ff, marker_sent_in;
   logic               halted_ff, halted_in;
   logic [UNIT_W-1:0]  partial_ff, partial_in;
   logic [1:0]         pend_ff, pend_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic               accept;
   logic               mark;
   logic               unit_v;
   logic [UNIT_W-1:0]  unit;
   logic [UNIT_W-1:0]  cont_bits;
   logic [UNIT_W-1:0]  merged;
   logic [1:0]         inc;
   logic [COUNT_W:0]   sum;

   // stall only on a full queue
   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   // decode one byte against the string state
   always_comb begin
      mark      = !marker_sent_ff;
      halted_in = halted_ff;
      partial_in = partial_ff;
      pend_in   = pend_ff;
      unit_v    = 1'b0;
      unit      = TERM_UNIT;
      cont_bits = (pend_ff == PEND_TWO) ? {4'd0, req_in_byte[5:0], 6'd0}
                                        : {10'd0, req_in_byte[5:0]};
      merged    = partial_ff | cont_bits;
      if (!halted_ff) begin
         if (pend_ff != PEND_NONE) begin
            pend_in = pend_ff - PEND_ONE;
            if (pend_in == PEND_NONE) begin
               unit_v     = 1'b1;
               unit       = merged;
               partial_in = '0;
            end else begin
               partial_in = merged;
            end
         end else if (req_in_byte[7:4] == LEAD3_TAG) begin
            partial_in = {req_in_byte[3:0], 12'd0};
            pend_in    = PEND_TWO;
         end else if (req_in_byte[7:5] == LEAD2_TAG) begin
            partial_in = {5'd0, req_in_byte[4:0], 6'd0};
            pend_in    = PEND_ONE;
         end else if (!req_in_byte[7]) begin
            unit_v = 1'b1;
            unit   = {8'd0, req_in_byte};
         end else begin
            halted_in = 1'b1;
         end
      end
      // truncated sequence at end of string
      if (req_end_of_string && (pend_in != PEND_NONE)) begin
         unit_v = 1'b1;
         unit   = partial_in;
      end
   end

   // saturating unit count
   always_comb begin
      inc      = {1'b0, mark} + {1'b0, unit_v};
      sum      = {1'b0, count_ff} + {{(COUNT_W-1){1'b0}}, inc};
      count_in = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
   end

   // record for the back end
   always_comb begin
      rec.mark   = mark;
      rec.unit_v = unit_v;
      rec.unit   = unit;
      rec.term   = req_end_of_string;
      rec.stop   = halted_in;
      rec.count  = count_in;
      push       = accept && (mark || unit_v || req_end_of_string);
   end

   // string state, cleared after the last word
   always_ff @(posedge clock) begin
      if (reset) begin
         marker_sent_ff <= 1'b0;
         halted_ff      <= 1'b0;
         partial_ff     <= '0;
         pend_ff        <= PEND_NONE;
         count_ff       <= '0;
      end else if (accept) begin
         if (req_end_of_string) begin
            marker_sent_ff <= 1'b0;
            halted_ff      <= 1'b0;
            partial_ff     <= '0;
            pend_ff        <= PEND_NONE;
            count_ff       <= '0;
         end else begin
            marker_sent_ff <= 1'b1;
            halted_ff      <= halted_in;
            partial_ff     <= partial_in;
            pend_ff        <= pend_in;
            count_ff       <= count_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/u8u16_queue.sv =====
// four-entry record queue between the decode front end and the output back end
// depends on u8u16_pkg
`default_nettype none

module u8u16_queue
   import u8u16_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rec_type push_rec,
   input  wire logic    pop,
   output rec_type      head_rec,
   output q_status_type q_status
);

   rec_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   // status and head
   always_comb begin
      q_status.full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
      q_status.not_empty = (count_ff != '0);
      head_rec           = entry_ff[rd_ptr_ff];
   end

   // pointer and fill updates
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

`default_nettype wire

// ===== design/u8u16_back.sv =====
// back end: expands queued records into result words, one per cycle while the output register is free, in string order
// depends on u8u16_pkg
`default_nettype none

module u8u16_back
   import u8u16_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire rec_type       head_rec,
   input  wire q_status_type  q_status,
   output logic               pop,
   input  wire logic          out_ready,
   output logic               word_valid,
   output logic [UNIT_W-1:0]  word_code_unit,
   output logic               word_final_unit,
   output logic               word_stopped_early,
   output logic [UNIT_W-1:0]  word_length_bytes
);

   // working record: pending result flags and payload
   logic               wmark_ff, wmark_in;
   logic               wunit_ff, wunit_in;
   logic               wterm_ff, wterm_in;
   logic [UNIT_W-1:0]  wunit_val_ff;
   logic               wstop_ff;
   logic [COUNT_W-1:0] wcount_ff;

   logic emit;
   logic am, au, at;

   assign word_valid = wmark_ff || wunit_ff || wterm_ff;
   assign emit       = out_ready && word_valid;

   // pick the next result of the working record, in order
   always_comb begin
      am                 = wmark_ff;
      au                 = wunit_ff;
      at                 = wterm_ff;
      word_code_unit     = TERM_UNIT;
      word_final_unit    = 1'b0;
      word_stopped_early = 1'b0;
      word_length_bytes  = '0;
      priority if (wmark_ff) begin
         word_code_unit = BOM_UNIT;
         am             = 1'b0;
      end else if (wunit_ff) begin
         word_code_unit = wunit_val_ff;
         au             = 1'b0;
      end else begin
         word_final_unit    = 1'b1;
         word_stopped_early = wstop_ff;
         word_length_bytes  = {wcount_ff, 1'b0};
         at                 = 1'b0;
      end
   end

   // refill the working record once it is spent
   always_comb begin
      if (emit) begin
         pop = !(am || au || at) && q_status.not_empty;
      end else begin
         pop = !word_valid && q_status.not_empty;
      end
      if (pop) begin
         wmark_in = head_rec.mark;
         wunit_in = head_rec.unit_v;
         wterm_in = head_rec.term;
      end else if (emit) begin
         wmark_in = am;
         wunit_in = au;
         wterm_in = at;
      end else begin
         wmark_in = wmark_ff;
         wunit_in = wunit_ff;
         wterm_in = wterm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wmark_ff <= 1'b0;
         wunit_ff <= 1'b0;
         wterm_ff <= 1'b0;
      end else begin
         wmark_ff <= wmark_in;
         wunit_ff <= wunit_in;
         wterm_ff <= wterm_in;
      end
   end

   // payload of the working record
   always_ff @(posedge clock) begin
      if (pop) begin
         wunit_val_ff <= head_rec.unit;
         wstop_ff     <= head_rec.stop;
         wcount_ff    <= head_rec.count;
      end
   end

endmodule

`default_nettype wire

// ===== design/u8u16_out.sv =====
// output register: holds one result word on the result port while the receiver stalls
// depends on u8u16_pkg
`default_nettype none

module u8u16_out
   import u8u16_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          word_valid,
   input  wire logic [UNIT_W-1:0] word_code_unit,
   input  wire logic          word_final_unit,
   input  wire logic          word_stopped_early,
   input  wire logic [UNIT_W-1:0] word_length_bytes,
   output logic               out_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [UNIT_W-1:0]  rsp_code_unit,
   output logic               rsp_final_unit,
   output logic               rsp_stopped_early,
   output logic [UNIT_W-1:0]  rsp_length_bytes
);

   logic               valid_ff, valid_in;
   logic [UNIT_W-1:0]  code_ff;
   logic               final_ff;
   logic               stop_ff;
   logic [UNIT_W-1:0]  len_ff;
   logic               load;

   // free when empty or when the held word leaves this cycle
   assign out_ready = !valid_ff || !rsp_stall;
   assign load      = out_ready && word_valid;
   assign valid_in  = out_ready ? word_valid : 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload held while stalled
   always_ff @(posedge clock) begin
      if (load) begin
         code_ff  <= word_code_unit;
         final_ff <= word_final_unit;
         stop_ff  <= word_stopped_early;
         len_ff   <= word_length_bytes;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_code_unit     = code_ff;
   assign rsp_final_unit    = final_ff;
   assign rsp_stopped_early = stop_ff;
   assign rsp_length_bytes  = len_ff;

endmodule

`default_nettype wire

// ===== design/utf8_to_utf16_bmp_decoder.sv =====
// UTF-8 to UTF-16 (BMP) decoder. One UTF-8 byte is taken per cycle as long as the
// four-entry record queue has room; each string starts with a 0xFEFF marker and
// ends with a zero terminator that carries the byte length (twice the units,
// marker included, saturating at 65534) and a flag for an invalid lead byte,
// after which the rest of the string is dropped. The single result port gives
// one unit per cycle while the receiver does not stall, so a byte that causes two or
// three units (the first byte, the last byte, a truncated sequence) holds the port
// for each of them in turn; a byte passes the queue, the working record and the
// output register on its way to the result port.
// depends on u8u16_pkg, u8u16_front, u8u16_queue, u8u16_back, u8u16_out
`default_nettype none

module utf8_to_utf16_bmp_decoder
   import u8u16_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [7:0]   req_in_byte,
   input  wire logic         req_end_of_string,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [15:0]       rsp_code_unit,
   output logic              rsp_final_unit,
   output logic              rsp_stopped_early,
   output logic [15:0]       rsp_length_bytes
);

   q_status_type      q_status;
   rec_type           push_rec;
   rec_type           head_rec;
   logic              push;
   logic              pop;
   logic              out_ready;
   logic              word_valid;
   logic [UNIT_W-1:0] word_code_unit;
   logic              word_final_unit;
   logic              word_stopped_early;
   logic [UNIT_W-1:0] word_length_bytes;

   // decode front end
   u8u16_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .req_stall         (req_stall),
      .q_status          (q_status),
      .push              (push),
      .rec               (push_rec)
   );

   // record queue
   u8u16_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .q_status (q_status)
   );

   // record expansion
   u8u16_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_rec           (head_rec),
      .q_status           (q_status),
      .pop                (pop),
      .out_ready          (out_ready),
      .word_valid         (word_valid),
      .word_code_unit     (word_code_unit),
      .word_final_unit    (word_final_unit),
      .word_stopped_early (word_stopped_early),
      .word_length_bytes  (word_length_bytes)
   );

   // output register
   u8u16_out u_out (
      .clock              (clock),
      .reset              (reset),
      .word_valid         (word_valid),
      .word_code_unit     (word_code_unit),
      .word_final_unit    (word_final_unit),
      .word_stopped_early (word_stopped_early),
      .word_length_bytes  (word_length_bytes),
      .out_ready          (out_ready),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_code_unit      (rsp_code_unit),
      .rsp_final_unit     (rsp_final_unit),
      .rsp_stopped_early  (rsp_stopped_early),
      .rsp_length_bytes   (rsp_length_bytes)
   );

   // queue never written when full nor read when empty
   a_push_room : assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("record pushed into a full queue");

   a_pop_data : assert property (@(posedge clock) disable iff (reset)
      pop |-> q_status.not_empty)
      else $error("record popped from an empty queue");

   // terminator is zero and always counts at least the marker
   a_term_word : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_final_unit) |->
         (rsp_code_unit == TERM_UNIT) && (rsp_length_bytes != '0) && !rsp_length_bytes[0])
      else $error("malformed terminator word");

   // status fields stay zero on ordinary words
   a_plain_word : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_final_unit) |-> !rsp_stopped_early && (rsp_length_bytes == '0))
      else $error("status set on a non-terminator word");

endmodule

`default_nettype wire
